// ===== hdl/mwns_pkg.sv =====
package mwns_pkg;

    // Fixed field widths of the stream payloads.
    localparam int WEIGHT_FIELD_W = 16;
    localparam int SUM_FIELD_W    = 22;
    localparam int COUNT_FIELD_W  = 6;
    localparam int POS_FIELD_W    = 7;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 40;

    // Parameter defaults.
    localparam int DEF_MAX_ITEMS   = 64;
    localparam int DEF_WEIGHT_BITS = 16;

    // Result kinds carried on m_tuser.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PICK   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // an input transaction is taken this cycle
        logic start_walk;  // the taken transaction closes the sequence
        logic walk;        // one backtrack step
        logic head;        // load the header result into the output register
        logic pop;         // load the next picked position into the output register
        logic clear;       // return the load state to its reset values
    } mwns_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;   // the backtrack has reached the front of the chain
        logic depth_zero;  // nothing was picked
        logic pop_last;    // the entry waiting in the stack read register is the last one
        logic out_free;    // the output register can take a result this cycle
    } mwns_status_t;

endpackage

// ===== hdl/mwns_ctrl.sv =====
module mwns_ctrl
    import mwns_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    input  mwns_status_t status,
    output mwns_cmd_t    cmd
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_HEAD = 2'd2;
    localparam logic [1:0] ST_POP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Input is taken only while the sequence is loading.
    assign s_tready = (state_reg == ST_LOAD);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.start_walk = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_done) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (status.out_free) begin
                    cmd.head = 1'b1;
                    if (status.depth_zero) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (status.out_free) begin
                    cmd.pop = 1'b1;
                    if (status.pop_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/mwns_datapath.sv =====
module mwns_datapath
    import mwns_pkg::*;
#(
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [WEIGHT_FIELD_W-1:0] s_weight,
    input  mwns_cmd_t                cmd,
    output mwns_status_t             status,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic                     m_kind,
    output logic [SUM_FIELD_W-1:0]   m_best_sum,
    output logic [COUNT_FIELD_W-1:0] m_pick_count,
    output logic [POS_FIELD_W-1:0]   m_position,
    output logic                     m_last
);

    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = WEIGHT_BITS + $clog2(MAX_ITEMS);
    localparam int EFF_W     = (WEIGHT_BITS < WEIGHT_FIELD_W) ? WEIGHT_BITS : WEIGHT_FIELD_W;
    localparam int STK_DEPTH = (MAX_ITEMS + 1) / 2;
    localparam int STK_IDX_W = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
    localparam int DEPTH_W   = $clog2(STK_DEPTH + 1);

    // Load state of the dynamic program.
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] bp_reg;
    logic [IDX_W-1:0] bp2_reg;
    logic [SUM_W-1:0] sum_prev_reg;
    logic [SUM_W-1:0] sum_prev2_reg;

    // Predecessor memory and backtrack stack.
    logic [CNT_W-1:0] pred_mem [MAX_ITEMS];
    logic [CNT_W-1:0] pred_rd_reg;
    logic [CNT_W-1:0] stk_mem [STK_DEPTH];
    logic [CNT_W-1:0] stk_rd_reg;
    logic             first_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] pop_idx_reg;

    // Output register.
    logic                     valid_reg;
    logic                     kind_reg;
    logic [SUM_FIELD_W-1:0]   sum_out_reg;
    logic [COUNT_FIELD_W-1:0] count_out_reg;
    logic [POS_FIELD_W-1:0]   pos_out_reg;
    logic                     last_out_reg;

    logic [SUM_W-1:0]   w_ext;
    logic               in_range;
    logic               first_two;
    logic               is_first;
    logic [SUM_W-1:0]   chain_sum;
    logic [CNT_W-1:0]   pred_wr;
    logic               better;
    logic [IDX_W-1:0]   fore;
    logic [SUM_W-1:0]   fore_sum;
    logic [CNT_W-1:0]   cur_sel;
    logic [CNT_W-1:0]   cur_m1;
    logic               walk_push;
    logic               stk_rd_en;
    logic [DEPTH_W-1:0] stk_raddr_full;
    logic [SUM_W+SUM_FIELD_W-1:0]     sum_wide;
    logic [DEPTH_W+COUNT_FIELD_W-1:0] count_wide;
    logic [CNT_W+POS_FIELD_W-1:0]     pos_wide;

    // One step of the recurrence: extend the best chain ending two or more back.
    always_comb begin
        w_ext     = SUM_W'(s_weight[EFF_W-1:0]);
        in_range  = (cnt_reg < CNT_W'(MAX_ITEMS));
        first_two = (cnt_reg < CNT_W'(2));
        is_first  = (cnt_reg == '0);
        chain_sum = first_two ? w_ext : (w_ext + sum_prev2_reg);
        pred_wr   = first_two ? '0 : (CNT_W'(bp2_reg) + CNT_W'(1));
        better    = (chain_sum > sum_prev_reg);
        if (is_first || better) begin
            fore     = is_first ? '0 : cnt_reg[IDX_W-1:0];
            fore_sum = chain_sum;
        end else begin
            fore     = bp_reg;
            fore_sum = sum_prev_reg;
        end
    end

    // Load state registers; ties keep the earlier end.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            cnt_reg       <= '0;
            bp_reg        <= '0;
            bp2_reg       <= '0;
            sum_prev_reg  <= '0;
            sum_prev2_reg <= '0;
        end else if (cmd.load && in_range) begin
            cnt_reg       <= cnt_reg + CNT_W'(1);
            bp2_reg       <= bp_reg;
            sum_prev2_reg <= sum_prev_reg;
            bp_reg        <= fore;
            sum_prev_reg  <= fore_sum;
        end
    end

    // The walk starts at the best end and then follows the read predecessor.
    assign cur_sel   = first_reg ? (CNT_W'(bp_reg) + CNT_W'(1)) : pred_rd_reg;
    assign cur_m1    = cur_sel - CNT_W'(1);
    assign walk_push = cmd.walk && (cur_sel != '0);

    // Predecessor memory: written while loading, read once per walk step that pushes a position.
    always_ff @(posedge aclk) begin
        if (cmd.load && in_range) begin
            pred_mem[cnt_reg[IDX_W-1:0]] <= pred_wr;
        end
        if (walk_push) begin
            pred_rd_reg <= pred_mem[cur_m1[IDX_W-1:0]];
        end
    end

    // Walk control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b0;
            depth_reg <= '0;
        end else if (cmd.start_walk) begin
            first_reg <= 1'b1;
            depth_reg <= '0;
        end else if (walk_push) begin
            first_reg <= 1'b0;
            depth_reg <= depth_reg + DEPTH_W'(1);
        end
    end

    // Stack read address: top of stack for the header, then one lower per pop.
    assign stk_rd_en      = cmd.head || (cmd.pop && (pop_idx_reg != '0));
    assign stk_raddr_full = cmd.head ? (depth_reg - DEPTH_W'(1)) : (pop_idx_reg - DEPTH_W'(1));

    // Backtrack stack: pushed during the walk, popped towards ascending positions.
    always_ff @(posedge aclk) begin
        if (walk_push) begin
            stk_mem[depth_reg[STK_IDX_W-1:0]] <= cur_sel;
        end
        if (stk_rd_en) begin
            stk_rd_reg <= stk_mem[stk_raddr_full[STK_IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_idx_reg <= '0;
        end else if (cmd.head) begin
            pop_idx_reg <= depth_reg - DEPTH_W'(1);
        end else if (cmd.pop) begin
            pop_idx_reg <= pop_idx_reg - DEPTH_W'(1);
        end
    end

    // Results are trimmed to their field widths.
    assign sum_wide   = {{SUM_FIELD_W{1'b0}}, sum_prev_reg};
    assign count_wide = {{COUNT_FIELD_W{1'b0}}, depth_reg};
    assign pos_wide   = {{POS_FIELD_W{1'b0}}, stk_rd_reg};

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.head || cmd.pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.head) begin
            kind_reg      <= KIND_HEADER;
            sum_out_reg   <= sum_wide[SUM_FIELD_W-1:0];
            count_out_reg <= count_wide[COUNT_FIELD_W-1:0];
            pos_out_reg   <= '0;
            last_out_reg  <= (depth_reg == '0);
        end else if (cmd.pop) begin
            kind_reg      <= KIND_PICK;
            sum_out_reg   <= '0;
            count_out_reg <= '0;
            pos_out_reg   <= pos_wide[POS_FIELD_W-1:0];
            last_out_reg  <= (pop_idx_reg == '0);
        end
    end

    // Status back to the controller.
    assign status.walk_done  = (cur_sel == '0);
    assign status.depth_zero = (depth_reg == '0);
    assign status.pop_last   = (pop_idx_reg == '0);
    assign status.out_free   = !valid_reg || m_ready;

    assign m_valid      = valid_reg;
    assign m_kind       = kind_reg;
    assign m_best_sum   = sum_out_reg;
    assign m_pick_count = count_out_reg;
    assign m_position   = pos_out_reg;
    assign m_last       = last_out_reg;

endmodule

// ===== hdl/max_weight_nonadjacent_subset_core.sv =====
// Maximum-weight subset of a weight sequence with no two neighbours picked.
//
// Input stream: one weight per transaction on s_tdata, s_tlast on the final
// weight. Weights beyond MAX_ITEMS are dropped; a marked one still ends the run.
// Loading does one sum add and one sum compare per weight, with
// the predecessor of each position written to an on-chip memory.
// After the last weight the block walks the predecessors back from the best
// end, one step per cycle through the predecessor memory read port. s_tready
// is low from then until the last result of the run has been loaded into the
// output register.
// Output stream: a header transaction (m_tuser = 0) with the best sum and the
// pick count, then one transaction per picked position (m_tuser = 1), 1-based,
// ascending; m_tlast marks the final one. Results leave at one per cycle
// while m_tready is high; the output register holds a result while it is
// low and the block waits; the next run can load while the last result is
// still waiting. Reset clears the loading state and the output valid; the
// memories need no clearing, since every entry is written before it is read.
module max_weight_nonadjacent_subset_core
    import mwns_pkg::*;
#(
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] weight
    input  logic                 s_tlast,   // last_item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [21:0] best_sum, [27:22] pick_count,
                                            // [34:28] position, [39:35] zero
    output logic                 m_tuser,   // [0] kind
    output logic                 m_tlast    // last_result
);

    mwns_cmd_t                cmd;
    mwns_status_t             status;
    logic [SUM_FIELD_W-1:0]   best_sum;
    logic [COUNT_FIELD_W-1:0] pick_count;
    logic [POS_FIELD_W-1:0]   position;

    mwns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mwns_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_weight     (s_tdata[WEIGHT_FIELD_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .m_ready      (m_tready),
        .m_valid      (m_tvalid),
        .m_kind       (m_tuser),
        .m_best_sum   (best_sum),
        .m_pick_count (pick_count),
        .m_position   (position),
        .m_last       (m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {{(M_TDATA_W - SUM_FIELD_W - COUNT_FIELD_W - POS_FIELD_W){1'b0}},
                      position, pick_count, best_sum};

`ifndef SYNTHESIS
    // The final weight of a run closes the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still taken after the final weight");

    // A header is always followed by at least one picked position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_HEADER)) |-> !m_tlast)
    else $error("header marked as final result");

    // Loading the header shows a header transaction in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.head |=> (m_tvalid && (m_tuser == KIND_HEADER)))
    else $error("header not presented after load");
`endif

endmodule

// ===== test/max_weight_nonadjacent_subset_core_tb.sv =====
module max_weight_nonadjacent_subset_core_tb;
    import mwns_pkg::*;

    localparam int SEQ_DEPTH      = DEF_MAX_ITEMS;
    localparam int PICK_DEPTH     = (DEF_MAX_ITEMS + 1) / 2;
    localparam int DIRECTED_N     = 21;
    localparam int RANDOM_WEIGHTS = 400;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PAD_LSB        = SUM_FIELD_W + COUNT_FIELD_W + POS_FIELD_W;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic                     kind;
        logic [SUM_FIELD_W-1:0]   best_sum;
        logic [COUNT_FIELD_W-1:0] pick_count;
        logic [POS_FIELD_W-1:0]   position;
        logic                     last_result;
    } result_t;

    // One row of the directed stimulus; typed rows carry a one-pick answer.
    typedef struct packed {
        logic [WEIGHT_FIELD_W-1:0] weight;
        logic                      last_flag;
        logic                      typed;
        logic [SUM_FIELD_W-1:0]    hdr_sum;
        logic [POS_FIELD_W-1:0]    pick_pos;
    } stim_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // Shadow copy of the chain state, in the block's own widths.
    logic [SUM_FIELD_W-1:0] chain_sum  [SEQ_DEPTH];
    logic [POS_FIELD_W-1:0] chain_pred [SEQ_DEPTH];
    int unsigned            prev_best;
    int unsigned            prev2_best;
    int unsigned            top_index;
    logic [SUM_FIELD_W-1:0] top_sum;
    int unsigned            loaded;

    result_t   run_results[$];
    result_t   pending_results[$];
    stim_row_t directed_rows [DIRECTED_N];

    int  mismatches       = 0;
    int  weights_accepted = 0;
    int  weights_stored   = 0;
    int  runs_closed      = 0;
    int  results_checked  = 0;
    int  cycle_count      = 0;
    bit  quiet_run        = 1'b0;

    max_weight_nonadjacent_subset_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Return the chain state to its state after reset.
    function automatic void clear_chain();
        prev_best  = 0;
        prev2_best = 0;
        top_index  = 0;
        top_sum    = '0;
        loaded     = 0;
    endfunction

    // Extend the best chains by one weight; returns 0 when the weight is dropped.
    function automatic bit absorb_weight(logic [WEIGHT_FIELD_W-1:0] w);
        logic [SUM_FIELD_W-1:0] s;
        int unsigned            fore;
        if (loaded >= SEQ_DEPTH) begin
            return 1'b0;
        end
        if (loaded < 2) begin
            s                  = SUM_FIELD_W'(w);
            chain_pred[loaded] = '0;
        end else begin
            s                  = SUM_FIELD_W'(w) + chain_sum[prev2_best];
            chain_pred[loaded] = POS_FIELD_W'(prev2_best + 1);
        end
        chain_sum[loaded] = s;
        if (loaded == 0) begin
            fore = 0;
        end else if (s > chain_sum[prev_best]) begin
            fore = loaded;
        end else begin
            fore = prev_best;
        end
        prev2_best = prev_best;
        prev_best  = fore;
        top_index  = fore;
        top_sum    = chain_sum[fore];
        loaded     = loaded + 1;
        return 1'b1;
    endfunction

    // Walk back from the best end and list the header and the picks, ascending.
    function automatic void close_sequence();
        int unsigned stack [PICK_DEPTH];
        int unsigned depth;
        int unsigned cur;
        int unsigned guard;
        result_t     r;
        depth = 0;
        cur   = top_index + 1;
        guard = 0;
        while (guard < SEQ_DEPTH && cur != 0 && depth < PICK_DEPTH) begin
            stack[depth] = cur;
            depth        = depth + 1;
            cur          = chain_pred[cur - 1];
            guard        = guard + 1;
        end
        r = '{KIND_HEADER, top_sum, COUNT_FIELD_W'(depth), '0, depth == 0};
        run_results.push_back(r);
        while (depth > 0) begin
            depth = depth - 1;
            r = '{KIND_PICK, '0, '0, POS_FIELD_W'(stack[depth]), depth == 0};
            run_results.push_back(r);
        end
        clear_chain();
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 25);
    endfunction

    function automatic logic [WEIGHT_FIELD_W-1:0] random_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end else if (r < 35) begin
            return WEIGHT_FIELD_W'($urandom_range(0, 3));
        end
        return WEIGHT_FIELD_W'($urandom);
    endfunction

    // Offer one weight, wait for its transaction, then update the expectations.
    task automatic offer_weight(input logic [WEIGHT_FIELD_W-1:0] w, input logic last_flag,
                                input logic typed, input logic [SUM_FIELD_W-1:0] t_sum,
                                input logic [POS_FIELD_W-1:0] t_pos);
        int gap;
        gap = sender_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last_flag;
        do @(posedge aclk); while (!s_tready);
        weights_accepted++;
        if (absorb_weight(w)) begin
            weights_stored++;
        end
        if (last_flag) begin
            run_results.delete();
            close_sequence();
            runs_closed++;
            if (typed) begin
                run_results.delete();
                run_results.push_back('{KIND_HEADER, t_sum, COUNT_FIELD_W'(1), '0, 1'b0});
                run_results.push_back('{KIND_PICK, '0, '0, t_pos, 1'b1});
            end
            foreach (run_results[k]) begin
                pending_results.push_back(run_results[k]);
            end
        end
    endtask

    // Receiver back-pressure: bursts of ready and stalls, mostly short.
    initial begin : ready_driver
        int  run_len;
        bit  hold;
        int  r;
        run_len = 0;
        hold    = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet_run) begin
                m_tready <= 1'b1;
            end else begin
                if (run_len == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 12) begin
                        hold    = 1'b1;
                        run_len = $urandom_range(5, 30);
                    end else if (r < 50) begin
                        hold    = 1'b1;
                        run_len = $urandom_range(1, 3);
                    end else begin
                        hold    = 1'b0;
                        run_len = $urandom_range(1, 20);
                    end
                end
                run_len--;
                m_tready <= !hold;
            end
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: tuser %0d tdata %h tlast %0d",
                         $time, m_tuser, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("kind", want.kind, m_tuser);
                check_field("best_sum", want.best_sum, m_tdata[SUM_FIELD_W-1:0]);
                check_field("pick_count", want.pick_count,
                            m_tdata[SUM_FIELD_W +: COUNT_FIELD_W]);
                check_field("position", want.position,
                            m_tdata[SUM_FIELD_W + COUNT_FIELD_W +: POS_FIELD_W]);
                check_field("tdata padding", 0, m_tdata[M_TDATA_W-1:PAD_LSB]);
                check_field("last_result", want.last_result, m_tlast);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int seq;
        int len;
        int r;
        int k;
        clear_chain();
        directed_rows = '{
            // Single maximum weight, then a single zero weight.
            '{16'hFFFF, 1'b1, 1'b1, 22'd65535, 7'd1},
            '{16'h0000, 1'b1, 1'b1, 22'd0,     7'd1},
            // All weights zero: one pick at the front.
            '{16'h0000, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'h0000, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'h0000, 1'b1, 1'b1, 22'd0,     7'd1},
            // Two weights, the second heavier.
            '{16'd5,    1'b0, 1'b0, 22'd0,     7'd0},
            '{16'd9,    1'b1, 1'b1, 22'd9,     7'd2},
            // Two equal weights: the earlier one is kept.
            '{16'd7,    1'b0, 1'b0, 22'd0,     7'd0},
            '{16'd7,    1'b1, 1'b1, 22'd7,     7'd1},
            // Heavy middle element between light neighbours.
            '{16'd1,    1'b0, 1'b0, 22'd0,     7'd0},
            '{16'hFFFF, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'd1,    1'b1, 1'b0, 22'd0,     7'd0},
            // Alternating extremes: every other element picked.
            '{16'hFFFF, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'h0000, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'hFFFF, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'h0000, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'hFFFF, 1'b1, 1'b0, 22'd0,     7'd0},
            // Bit patterns on the weight.
            '{16'hAAAA, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'h5555, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'h0001, 1'b0, 1'b0, 22'd0,     7'd0},
            '{16'h8000, 1'b1, 1'b0, 22'd0,     7'd0}
        };

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_weight(directed_rows[i].weight, directed_rows[i].last_flag,
                         directed_rows[i].typed, directed_rows[i].hdr_sum,
                         directed_rows[i].pick_pos);
        end

        // Random sequences: mostly short, some long, a few past the store depth.
        seq = 0;
        while (weights_stored < DIRECTED_N + RANDOM_WEIGHTS) begin
            r = $urandom_range(0, 99);
            if (seq == 0) begin
                len = SEQ_DEPTH + 6;
            end else if (seq == 1) begin
                len = SEQ_DEPTH;
            end else if (r < 70) begin
                len = $urandom_range(1, 10);
            end else if (r < 85) begin
                len = $urandom_range(11, 40);
            end else if (r < 93) begin
                len = $urandom_range(SEQ_DEPTH - 4, SEQ_DEPTH);
            end else begin
                len = $urandom_range(SEQ_DEPTH + 1, SEQ_DEPTH + 8);
            end
            quiet_run = ($urandom_range(0, 4) == 0);
            for (k = 0; k < len; k++) begin
                offer_weight(random_weight(), k == len - 1, 1'b0, '0, '0);
            end
            seq++;
        end
        quiet_run = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            mismatches++;
        end

        $display("Ran %0d sequences of 1 to %0d weights (%0d offered, %0d stored).",
                 runs_closed, SEQ_DEPTH + 8, weights_accepted, weights_stored);
        $display("Checked %0d result transactions, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mwns_pkg.sv
hdl/mwns_ctrl.sv
hdl/mwns_datapath.sv
hdl/max_weight_nonadjacent_subset_core.sv
test/max_weight_nonadjacent_subset_core_tb.sv
